// ----- rtl/imh_pkg.sv -----
package imh_pkg;

	localparam int KEY_BITS = 64;
	localparam int POS_BITS = 10;
	localparam int TOTAL_BITS = 11;
	localparam int HANDLE_PORT_BITS = 16;

	localparam logic OP_UPSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic KIND_MOVE = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_DELETE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// One command word as it travels from the front end to the engine.
	typedef struct packed {
		logic                        opcode;
		logic [POS_BITS-1:0]         position;
		logic [KEY_BITS-1:0]         key_value;
		logic [HANDLE_PORT_BITS-1:0] owner_handle;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic                        kind;
		logic [HANDLE_PORT_BITS-1:0] moved_handle;
		logic [POS_BITS-1:0]         new_position;
		logic [1:0]                  status;
		logic [TOTAL_BITS-1:0]       entry_total;
		logic [KEY_BITS-1:0]         min_key;
		logic [HANDLE_PORT_BITS-1:0] min_handle;
		logic                        last;
	} res_t;

endpackage

// ----- rtl/imh_fifo.sv -----
module imh_fifo import imh_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH_BITS = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int DEPTH = 1 << DEPTH_BITS;

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [DEPTH_BITS:0] wp_q;
	logic [DEPTH_BITS:0] rp_q;

	assign empty = (wp_q == rp_q);
	assign full = (wp_q[DEPTH_BITS-1:0] == rp_q[DEPTH_BITS-1:0]) &&
		(wp_q[DEPTH_BITS] != rp_q[DEPTH_BITS]);
	assign rd_data = mem_q[rp_q[DEPTH_BITS-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wp_q[DEPTH_BITS-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_en && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/imh_engine.sv -----
module imh_engine import imh_pkg::*; #(
	parameter int CAPACITY = 1024,
	parameter int HANDLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_take,
	output logic res_push,
	output res_t res,
	input  logic res_full
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (AW > POS_BITS) ? AW : POS_BITS;
	localparam int XW = PW + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_RDLAST, S_WRHOLE, S_RDSELF, S_DECIDE,
		S_UPRD, S_UPCMP, S_DNRD1, S_DNRD2, S_DNCMP, S_PLACE, S_DONERD, S_DONE
	} state_t;

	logic [KEY_BITS-1:0]    keys_q [CAPACITY];
	logic [HANDLE_BITS-1:0] hnds_q [CAPACITY];

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [AW-1:0]          pos_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [1:0]             status_q;
	logic [KEY_BITS-1:0]    rk_q;
	logic [HANDLE_BITS-1:0] rh_q;
	logic [KEY_BITS-1:0]    lk_q;
	logic [HANDLE_BITS-1:0] lh_q;
	logic                   lvalid_q;
	logic                   rvalid_q;

	logic                   we;
	logic [AW-1:0]          waddr;
	logic [KEY_BITS-1:0]    wkey;
	logic [HANDLE_BITS-1:0] whnd;
	logic [AW-1:0]          raddr;

	logic [PW-1:0]          cmd_pos;
	logic [XW-1:0]          lc_x;
	logic [XW-1:0]          rc_x;
	logic [AW-1:0]          par;
	logic                   write_busy;

	assign cmd_pos = PW'(cmd.position);
	assign lc_x = XW'({pos_q, 1'b1});
	assign rc_x = lc_x + 1'b1;
	assign par = AW'((pos_q - 1'b1) >> 1);

	// A slot write that produces a report needs room in the result queue.
	assign write_busy = res_full;

	always_comb begin
		cmd_take = (state_q == S_IDLE) && cmd_valid;
		we = 1'b0;
		waddr = pos_q;
		wkey = key_q;
		whnd = hnd_q;
		raddr = pos_q;
		res_push = 1'b0;
		res = '0;
		case (state_q)
			S_RDLAST: begin
				// The count already excludes the last entry, so it indexes it.
				raddr = AW'(count_q);
			end
			S_WRHOLE: begin
				we = 1'b1;
				wkey = rk_q;
				whnd = rh_q;
			end
			S_DECIDE: begin
				raddr = par;
			end
			S_RDSELF: begin
				raddr = par;
			end
			S_UPRD: begin
				raddr = par;
			end
			S_UPCMP: begin
				// Keep the parent read going so a stalled compare sees the same data.
				raddr = par;
				if (pos_q != '0 && rk_q > key_q) begin
					we = !(pos_q != '0 && write_busy);
					wkey = rk_q;
					whnd = rh_q;
					res_push = we;
				end
			end
			S_DNRD1: begin
				raddr = lc_x[AW-1:0];
			end
			S_DNRD2: begin
				raddr = rc_x[AW-1:0];
			end
			S_DNCMP: begin
				raddr = rc_x[AW-1:0];
				if (lvalid_q && lk_q < key_q && !(rvalid_q && rk_q < lk_q)) begin
					we = !write_busy || pos_q == '0;
					wkey = lk_q;
					whnd = lh_q;
					res_push = we && pos_q != '0;
				end else if (rvalid_q && rk_q < key_q) begin
					we = !write_busy || pos_q == '0;
					wkey = rk_q;
					whnd = rh_q;
					res_push = we && pos_q != '0;
				end
			end
			S_PLACE: begin
				we = !(pos_q != '0 && write_busy);
				res_push = we && pos_q != '0;
			end
			S_DONERD: begin
				raddr = '0;
			end
			S_DONE: begin
				raddr = '0;
				res_push = !res_full;
				res.kind = KIND_DONE;
				res.status = status_q;
				res.entry_total = TOTAL_BITS'(count_q);
				if (count_q != '0) begin
					res.min_key = rk_q;
					res.min_handle = HANDLE_PORT_BITS'(rh_q);
				end
				res.last = 1'b1;
			end
			default: begin
			end
		endcase
		if (res_push && state_q != S_DONE) begin
			res.kind = KIND_MOVE;
			res.moved_handle = HANDLE_PORT_BITS'(whnd);
			res.new_position = POS_BITS'(waddr);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			keys_q[waddr] <= wkey;
			hnds_q[waddr] <= whnd;
		end
		rk_q <= keys_q[raddr];
		rh_q <= hnds_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pos_q <= '0;
			key_q <= '0;
			hnd_q <= '0;
			status_q <= ST_OK;
			lk_q <= '0;
			lh_q <= '0;
			lvalid_q <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						status_q <= ST_OK;
						key_q <= cmd.key_value;
						hnd_q <= HANDLE_BITS'(cmd.owner_handle);
						if (cmd.opcode == OP_UPSERT) begin
							if ({1'b0, cmd_pos} < (PW+1)'(count_q)) begin
								pos_q <= AW'(cmd_pos);
								state_q <= S_DECIDE;
							end else if (count_q >= CW'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q <= S_DONERD;
							end else begin
								pos_q <= AW'(count_q);
								count_q <= count_q + 1'b1;
								state_q <= S_DECIDE;
							end
						end else begin
							if ({1'b0, cmd_pos} >= (PW+1)'(count_q)) begin
								status_q <= ST_BAD_DELETE;
								state_q <= S_DONERD;
							end else begin
								pos_q <= AW'(cmd_pos);
								count_q <= count_q - 1'b1;
								if ((PW+1)'(cmd_pos) == (PW+1)'(count_q - 1'b1)) begin
									state_q <= S_DONERD;
								end else begin
									state_q <= S_RDLAST;
								end
							end
						end
					end
				end
				S_RDLAST: begin
					state_q <= S_WRHOLE;
				end
				S_WRHOLE: begin
					key_q <= rk_q;
					hnd_q <= rh_q;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					// Parent read is issued this cycle.
					state_q <= S_RDSELF;
				end
				S_RDSELF: begin
					if (pos_q != '0 && rk_q > key_q) begin
						state_q <= S_UPCMP;
					end else begin
						state_q <= S_DNRD1;
					end
				end
				S_UPRD: begin
					state_q <= S_UPCMP;
				end
				S_UPCMP: begin
					if (pos_q != '0 && rk_q > key_q) begin
						if (we) begin
							pos_q <= par;
							state_q <= S_UPRD;
						end
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_DNRD1: begin
					state_q <= S_DNRD2;
				end
				S_DNRD2: begin
					lk_q <= rk_q;
					lh_q <= rh_q;
					lvalid_q <= lc_x < XW'(count_q);
					rvalid_q <= rc_x < XW'(count_q);
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (lvalid_q && lk_q < key_q && !(rvalid_q && rk_q < lk_q)) begin
						if (we) begin
							pos_q <= lc_x[AW-1:0];
							state_q <= S_DNRD1;
						end
					end else if (rvalid_q && rk_q < key_q) begin
						if (we) begin
							pos_q <= rc_x[AW-1:0];
							state_q <= S_DNRD1;
						end
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					if (we) begin
						state_q <= S_DONERD;
					end
				end
				S_DONERD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/indexed_min_heap.sv -----
// Indexed binary min-heap of up to CAPACITY entries, each a 64-bit key with an
// owner handle. Push a command word (upsert or delete at a slot) while full is
// low; the block answers with one position report word for every entry that
// lands in a new slot other than the root, then a closing word (last = 1) with
// status, entry count and the current minimum. A two-word command queue
// decouples the port from the heap engine, and a four-word result queue lets
// the engine run ahead of pop. The heap memory has one read and one write port:
// a level of upward sifting reads the parent, then compares and writes; a
// level of downward sifting reads the two children, then compares and writes.
// Around the sifting, a command is accepted, reads the first parent and checks
// itself, places the entry, reads the root and sends the closing word; the last
// level down still reads both children, and a delete that refills its hole
// first reads the last entry and writes it there. A rejected command, like a
// delete of the last slot, only reads the root and sends the closing word. A
// full result queue stalls every write that reports and the closing word.
// Heap slots are not cleared at reset; only slots below the count are used.
module indexed_min_heap import imh_pkg::*; #(
	parameter int CAPACITY = 1024,
	parameter int HANDLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        opcode,
	input  logic [POS_BITS-1:0]         position,
	input  logic [KEY_BITS-1:0]         key_value,
	input  logic [HANDLE_PORT_BITS-1:0] owner_handle,
	output logic                        empty,
	input  logic                        pop,
	output logic                        kind,
	output logic [HANDLE_PORT_BITS-1:0] moved_handle,
	output logic [POS_BITS-1:0]         new_position,
	output logic [1:0]                  status,
	output logic [TOTAL_BITS-1:0]       entry_total,
	output logic [KEY_BITS-1:0]         min_key,
	output logic [HANDLE_PORT_BITS-1:0] min_handle,
	output logic                        last
);

	cmd_t in_cmd;
	cmd_t q_cmd;
	logic cmd_empty;
	logic cmd_take;
	logic res_push;
	logic res_full;
	res_t eng_res;
	res_t out_res;

	// The owner handle keeps only its low HANDLE_BITS bits.
	always_comb begin
		in_cmd.opcode = opcode;
		in_cmd.position = position;
		in_cmd.key_value = key_value;
		in_cmd.owner_handle = HANDLE_PORT_BITS'(owner_handle[HANDLE_BITS-1:0]);
	end

	imh_fifo #(.WIDTH($bits(cmd_t)), .DEPTH_BITS(1)) u_cmd_q (
		.clk(clk), .arst_n(arst_n),
		.wr_en(push), .wr_data(in_cmd), .full(full),
		.rd_en(cmd_take), .rd_data(q_cmd), .empty(cmd_empty)
	);

	imh_engine #(.CAPACITY(CAPACITY), .HANDLE_BITS(HANDLE_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(!cmd_empty), .cmd(q_cmd), .cmd_take(cmd_take),
		.res_push(res_push), .res(eng_res), .res_full(res_full)
	);

	imh_fifo #(.WIDTH($bits(res_t)), .DEPTH_BITS(2)) u_res_q (
		.clk(clk), .arst_n(arst_n),
		.wr_en(res_push), .wr_data(eng_res), .full(res_full),
		.rd_en(pop), .rd_data(out_res), .empty(empty)
	);

	assign kind = out_res.kind;
	assign moved_handle = out_res.moved_handle;
	assign new_position = out_res.new_position;
	assign status = out_res.status;
	assign entry_total = out_res.entry_total;
	assign min_key = out_res.min_key;
	assign min_handle = out_res.min_handle;
	assign last = out_res.last;

endmodule

// ----- sim/indexed_min_heap_checker.sv -----
module indexed_min_heap_checker import imh_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        full,
	input  logic                        opcode,
	input  logic [POS_BITS-1:0]         position,
	input  logic [KEY_BITS-1:0]         key_value,
	input  logic [HANDLE_PORT_BITS-1:0] owner_handle,
	input  logic                        empty,
	input  logic                        pop,
	input  res_t                        res_word,
	output int                          errors,
	output int                          pending,
	output int                          heap_count,
	output int                          words_seen
);

	localparam int CAP = 1024;

	logic [KEY_BITS-1:0]         heap_key [CAP];
	logic [HANDLE_PORT_BITS-1:0] heap_hnd [CAP];
	int                          count;
	res_t                        expected_words [$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	function automatic void write_slot(int slot, logic [KEY_BITS-1:0] k,
			logic [HANDLE_PORT_BITS-1:0] h);
		res_t r;
		heap_key[slot] = k;
		heap_hnd[slot] = h;
		if (slot != 0) begin
			r = '0;
			r.kind = KIND_MOVE;
			r.moved_handle = h;
			r.new_position = POS_BITS'(slot);
			expected_words = {expected_words, r};
		end
	endfunction

	function automatic void settle_entry(int slot);
		logic [KEY_BITS-1:0] k;
		logic [HANDLE_PORT_BITS-1:0] h;
		int best, par;
		logic [KEY_BITS-1:0] bval;
		k = heap_key[slot];
		h = heap_hnd[slot];
		if (slot > 0 && heap_key[(slot - 1) / 2] > k) begin
			while (slot > 0) begin
				par = (slot - 1) / 2;
				if (!(heap_key[par] > k)) break;
				write_slot(slot, heap_key[par], heap_hnd[par]);
				slot = par;
			end
		end else begin
			forever begin
				best = slot;
				bval = k;
				if (2 * slot + 1 < count && heap_key[2 * slot + 1] < bval) begin
					best = 2 * slot + 1;
					bval = heap_key[best];
				end
				if (2 * slot + 2 < count && heap_key[2 * slot + 2] < bval)
					best = 2 * slot + 2;
				if (best == slot) break;
				write_slot(slot, heap_key[best], heap_hnd[best]);
				slot = best;
			end
		end
		write_slot(slot, k, h);
	endfunction

	function automatic void apply_command(logic op, int pos, logic [KEY_BITS-1:0] k,
			logic [HANDLE_PORT_BITS-1:0] h);
		res_t done;
		done = '0;
		done.kind = KIND_DONE;
		done.status = ST_OK;
		done.last = 1'b1;
		if (op == OP_UPSERT) begin
			if (pos < count) begin
				heap_key[pos] = k;
				heap_hnd[pos] = h;
				settle_entry(pos);
			end else if (count >= CAP) begin
				done.status = ST_FULL;
			end else begin
				heap_key[count] = k;
				heap_hnd[count] = h;
				count++;
				settle_entry(count - 1);
			end
		end else if (pos >= count) begin
			done.status = ST_BAD_DELETE;
		end else begin
			heap_key[pos] = heap_key[count - 1];
			heap_hnd[pos] = heap_hnd[count - 1];
			count--;
			if (pos < count) settle_entry(pos);
		end
		done.entry_total = TOTAL_BITS'(count);
		if (count > 0) begin
			done.min_key = heap_key[0];
			done.min_handle = heap_hnd[0];
		end
		expected_words = {expected_words, done};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			count = 0;
			errors = 0;
			words_seen = 0;
			expected_words.delete();
		end else begin
			if (pop && !empty) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", res_word.min_key, 64'h0);
				end else begin
					want = expected_words.pop_front();
					if (res_word.kind !== want.kind)
						report_mismatch("kind", 64'(res_word.kind), 64'(want.kind));
					if (res_word.moved_handle !== want.moved_handle)
						report_mismatch("moved_handle", 64'(res_word.moved_handle),
							64'(want.moved_handle));
					if (res_word.new_position !== want.new_position)
						report_mismatch("new_position", 64'(res_word.new_position),
							64'(want.new_position));
					if (res_word.status !== want.status)
						report_mismatch("status", 64'(res_word.status),
							64'(want.status));
					if (res_word.entry_total !== want.entry_total)
						report_mismatch("entry_total", 64'(res_word.entry_total),
							64'(want.entry_total));
					if (res_word.min_key !== want.min_key)
						report_mismatch("min_key", res_word.min_key, want.min_key);
					if (res_word.min_handle !== want.min_handle)
						report_mismatch("min_handle", 64'(res_word.min_handle),
							64'(want.min_handle));
					if (res_word.last !== want.last)
						report_mismatch("last", 64'(res_word.last), 64'(want.last));
				end
			end
			if (push && !full)
				apply_command(opcode, int'(position), key_value, owner_handle);
		end
		pending = expected_words.size();
		heap_count = count;
	end

endmodule

// ----- sim/indexed_min_heap_tb.sv -----
// Testbench top for the indexed min-heap. It drives command words into the
// block and pops result words with random idle bursts; the checker beside the
// block keeps a shadow heap, predicts every word and counts mismatches.
module indexed_min_heap_tb;
	import imh_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 360;

	logic                        clk;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	logic                        opcode;
	logic [POS_BITS-1:0]         position;
	logic [KEY_BITS-1:0]         key_value;
	logic [HANDLE_PORT_BITS-1:0] owner_handle;
	logic                        empty;
	logic                        pop;
	res_t                        res_word;
	int                          errors, pending, heap_count, words_seen;
	int                          idle_cycles;
	int                          commands_sent;
	bit                          calm;

	indexed_min_heap uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.position(position), .key_value(key_value), .owner_handle(owner_handle),
		.empty(empty), .pop(pop), .kind(res_word.kind),
		.moved_handle(res_word.moved_handle), .new_position(res_word.new_position),
		.status(res_word.status), .entry_total(res_word.entry_total),
		.min_key(res_word.min_key), .min_handle(res_word.min_handle),
		.last(res_word.last)
	);

	indexed_min_heap_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.position(position), .key_value(key_value), .owner_handle(owner_handle),
		.empty(empty), .pop(pop), .res_word(res_word), .errors(errors),
		.pending(pending), .heap_count(heap_count), .words_seen(words_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The watchdog counts cycles in which no word moves on either side. The
	// drain pause and the final wait move no input words, but result words
	// keep flowing then, so a healthy block always resets the counter.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d words outstanding", pending);
			$display("FAIL indexed_min_heap");
			$finish;
		end
	end

	// The receiver stalls in bursts of random length until the calm phase.
	initial begin
		int burst;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(3) == 0) begin
				burst = $urandom_range(9, 1);
				pop <= 1'b0;
				repeat (burst) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(12, 1)) @(posedge clk);
			end
		end
	end

	// Holds one command word until it is accepted. The word stays put while
	// full is high, and push falls only when the next word needs a gap.
	task automatic send_word(input logic op, input int pos, input logic [63:0] k,
			input logic [15:0] h);
		push <= 1'b1;
		opcode <= op;
		position <= POS_BITS'(pos);
		key_value <= k;
		owner_handle <= h;
		do @(posedge clk); while (full);
		commands_sent++;
		if (!calm && $urandom_range(4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(9, 1)) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] random_key();
		case ($urandom_range(3))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(40));
			2: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
			default: return {32'h0, $urandom};
		endcase
	endfunction

	initial begin
		int pos;
		arst_n = 1'b0;
		push = 1'b0;
		opcode = OP_UPSERT;
		position = '0;
		key_value = '0;
		owner_handle = '0;
		idle_cycles = 0;
		commands_sent = 0;
		calm = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-heap delete, key extremes, equal keys, delete of
		// the last slot, overwrite of the root, handle extremes.
		send_word(OP_DELETE, 0, 64'h0, 16'h0);
		send_word(OP_UPSERT, 1023, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		send_word(OP_UPSERT, 0, 64'h0, 16'h0001);
		send_word(OP_UPSERT, 5, 64'h8000_0000_0000_0000, 16'h8000);
		send_word(OP_UPSERT, 7, 64'h8000_0000_0000_0000, 16'h7FFF);
		send_word(OP_UPSERT, 9, 64'h0, 16'h00AA);
		send_word(OP_UPSERT, 9, 64'h0000_0000_0000_0001, 16'h5555);
		send_word(OP_DELETE, 5, 64'h0, 16'h0);
		send_word(OP_DELETE, 4, 64'h0, 16'h0);
		send_word(OP_UPSERT, 0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hAAAA);
		send_word(OP_UPSERT, 2, 64'h0, 16'h1234);
		send_word(OP_DELETE, 0, 64'h0, 16'h0);
		send_word(OP_DELETE, 1023, 64'h0, 16'h0);
		send_word(OP_UPSERT, 1, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0F0F);

		// Let the block run dry once before the random part.
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		// Random part: mostly appends and overwrites to grow a deep heap, with
		// deletes mixed in and occasional out-of-range deletes.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i > RANDOM_ITEMS - 60) calm = 1'b1;
			case ($urandom_range(9))
				0, 1, 2, 3: send_word(OP_UPSERT, 1023 - int'($urandom_range(3)),
					random_key(), 16'($urandom));
				4, 5: begin
					pos = (heap_count > 0) ? int'($urandom_range(heap_count - 1)) : 0;
					send_word(OP_UPSERT, pos, random_key(), 16'($urandom));
				end
				6, 7, 8: begin
					pos = (heap_count > 0) ? int'($urandom_range(heap_count - 1)) : 0;
					send_word(OP_DELETE, pos, 64'h0, 16'($urandom));
				end
				default: send_word(OP_DELETE, int'($urandom_range(1023)), random_key(),
					16'($urandom));
			endcase
		end
		push <= 1'b0;
		@(posedge clk);

		wait (pending == 0);
		repeat (60) @(posedge clk);
		$display("Sent %0d command words and checked %0d result words,", commands_sent,
			words_seen);
		$display("covering appends, overwrites, deletes and out-of-range deletes.");
		if (errors == 0 && pending == 0)
			$display("PASS indexed_min_heap");
		else
			$display("FAIL indexed_min_heap");
		$finish;
	end

endmodule
